// ----- rtl/atb_pkg.sv -----
// Package: shared types, register codes and reset values of the task-file address builder.
`default_nettype none
package atb_pkg;

    localparam int DIV_STAGES  = 8;
    localparam int STAGE_BITS  = 8;
    localparam int ADDR_W      = 4;

    localparam logic [1:0] REG_USE_LBA = 2'd0;
    localparam logic [1:0] REG_SPT     = 2'd1;
    localparam logic [1:0] REG_HEADS   = 2'd2;
    localparam logic [1:0] REG_SELECT  = 2'd3;

    localparam logic       RST_USE_LBA = 1'b0;
    localparam logic [7:0] RST_SPT     = 8'd63;
    localparam logic [4:0] RST_HEADS   = 5'd16;
    localparam logic [7:0] RST_SELECT  = 8'd160;

    localparam logic [3:0] LBA_NIBBLE_MASK = 4'hF;
    localparam logic [7:0] LBA_MODE_FLAG   = 8'h40;

    typedef struct packed {
        logic       use_lba;
        logic [7:0] spt;
        logic [4:0] heads;
        logic [7:0] sel;
    } cfg_t;

    typedef struct packed {
        logic [31:0] blk;
        logic [7:0]  cnt;
        logic [7:0]  cmd;
        logic [31:0] num;
        logic [7:0]  rem;
        logic [7:0]  rem1;
    } div_t;

    typedef struct packed {
        logic [7:0] count_byte;
        logic [7:0] sector_byte;
        logic [7:0] cylinder_low;
        logic [7:0] cylinder_high;
        logic [7:0] drive_head_byte;
        logic [7:0] command_byte_out;
        logic       address_overflow;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/ata_taskfile_address_builder.sv -----
// Top level: ATA task-file address builder, LBA or CHS, pipelined divider.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid/in_ready, block_number, ...      | in
//  result  | out_valid/out_ready, count_byte, ...      | out
//  config  | psel/penable/pwrite/paddr/pwdata/prdata   | in/out
//
// One transaction per cycle while the output is not stalled; eight divider stages
// of eight quotient bits each (four per division) plus the output register.
// Reset clears all valid bits and loads register defaults.
// A stall holds each occupied stage; empty stages keep filling behind it.
`default_nettype none
module ata_taskfile_address_builder (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output      logic                       in_ready,
    input  wire logic [31:0]                block_number,
    input  wire logic [7:0]                 sector_count,
    input  wire logic [7:0]                 command_code,
    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      logic [7:0]                 count_byte,
    output      logic [7:0]                 sector_byte,
    output      logic [7:0]                 cylinder_low,
    output      logic [7:0]                 cylinder_high,
    output      logic [7:0]                 drive_head_byte,
    output      logic [7:0]                 command_byte_out,
    output      logic                       address_overflow,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [atb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output      logic [31:0]                prdata,
    output      logic                       pready
);

    atb_pkg::cfg_t    cfg;
    atb_pkg::result_t res;
    logic [7:0]       spt_eff;
    logic [7:0]       hc_eff;

    logic             v   [atb_pkg::DIV_STAGES+1];
    logic             rdy [atb_pkg::DIV_STAGES+1];
    atb_pkg::div_t    d   [atb_pkg::DIV_STAGES+1];

    atb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // zero divisors act as one
    assign spt_eff = (cfg.spt == 8'd0) ? 8'd1 : cfg.spt;
    assign hc_eff  = (cfg.heads == 5'd0) ? 8'd1 : {3'd0, cfg.heads};

    assign v[0]      = in_valid;
    assign in_ready  = rdy[0];
    assign d[0].blk  = block_number;
    assign d[0].cnt  = sector_count;
    assign d[0].cmd  = command_code;
    assign d[0].num  = block_number;
    assign d[0].rem  = 8'd0;
    assign d[0].rem1 = 8'd0;

    for (genvar k = 0; k < atb_pkg::DIV_STAGES; k++)
    begin : g_div
        atb_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[k]),
            .in_ready  (rdy[k]),
            .in_data   (d[k]),
            .divisor   ((k < atb_pkg::DIV_STAGES / 2) ? spt_eff : hc_eff),
            .start     (k == atb_pkg::DIV_STAGES / 2),
            .out_valid (v[k+1]),
            .out_ready (rdy[k+1]),
            .out_data  (d[k+1])
        );
    end

    atb_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v[atb_pkg::DIV_STAGES]),
        .in_ready  (rdy[atb_pkg::DIV_STAGES]),
        .in_data   (d[atb_pkg::DIV_STAGES]),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res)
    );

    assign count_byte       = res.count_byte;
    assign sector_byte      = res.sector_byte;
    assign cylinder_low     = res.cylinder_low;
    assign cylinder_high    = res.cylinder_high;
    assign drive_head_byte  = res.drive_head_byte;
    assign command_byte_out = res.command_byte_out;
    assign address_overflow = res.address_overflow;

endmodule
`default_nettype wire

// ----- rtl/atb_cfg.sv -----
// Configuration registers behind the APB-style port.
`default_nettype none
module atb_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [atb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output      logic [31:0]               prdata,
    output      logic                      pready,
    output      atb_pkg::cfg_t             cfg
);

    atb_pkg::cfg_t cfg_reg;
    atb_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                atb_pkg::REG_USE_LBA: cfg_next.use_lba = pwdata[0];
                atb_pkg::REG_SPT:     cfg_next.spt     = pwdata[7:0];
                atb_pkg::REG_HEADS:   cfg_next.heads   = pwdata[4:0];
                atb_pkg::REG_SELECT:  cfg_next.sel     = pwdata[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            atb_pkg::REG_USE_LBA: prdata = {31'd0, cfg_reg.use_lba};
            atb_pkg::REG_SPT:     prdata = {24'd0, cfg_reg.spt};
            atb_pkg::REG_HEADS:   prdata = {27'd0, cfg_reg.heads};
            atb_pkg::REG_SELECT:  prdata = {24'd0, cfg_reg.sel};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_lba <= atb_pkg::RST_USE_LBA;
            cfg_reg.spt     <= atb_pkg::RST_SPT;
            cfg_reg.heads   <= atb_pkg::RST_HEADS;
            cfg_reg.sel     <= atb_pkg::RST_SELECT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/atb_div_stage.sv -----
// One divider pipeline stage: eight restoring quotient bits, registered with valid.
`default_nettype none
module atb_div_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output      logic          in_ready,
    input  wire atb_pkg::div_t in_data,
    input  wire logic [7:0]    divisor,
    input  wire logic          start,
    output      logic          out_valid,
    input  wire logic          out_ready,
    output      atb_pkg::div_t out_data
);

    logic          valid_reg;
    atb_pkg::div_t data_reg;
    atb_pkg::div_t data_next;
    logic [7:0]    r;
    logic [8:0]    t;
    logic [31:0]   n;

    // start: first stage of a new division, the running remainder moves to rem1
    always_comb
    begin
        data_next = in_data;
        r         = start ? 8'd0 : in_data.rem;
        n         = in_data.num;
        t         = 9'd0;
        if (start)
        begin
            data_next.rem1 = in_data.rem;
        end
        for (int i = 0; i < atb_pkg::STAGE_BITS; i++)
        begin
            t = {r, n[31]};
            n = {n[30:0], 1'b0};
            if (t >= {1'b0, divisor})
            begin
                t    = t - {1'b0, divisor};
                n[0] = 1'b1;
            end
            r = t[7:0];
        end
        data_next.num = n;
        data_next.rem = r;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/atb_format.sv -----
// Output stage: forms the task-file bytes for LBA or CHS and holds the result register.
`default_nettype none
module atb_format (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire atb_pkg::div_t    in_data,
    input  wire atb_pkg::cfg_t    cfg,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      atb_pkg::result_t out_data
);

    logic             valid_reg;
    atb_pkg::result_t res_reg;
    atb_pkg::result_t res_next;
    logic [7:0]       head;

    always_comb
    begin
        res_next.count_byte       = in_data.cnt;
        res_next.command_byte_out = in_data.cmd;
        if (cfg.use_lba)
        begin
            res_next.sector_byte      = in_data.blk[7:0];
            res_next.cylinder_low     = in_data.blk[15:8];
            res_next.cylinder_high    = in_data.blk[23:16];
            head = {4'd0, in_data.blk[27:24] & atb_pkg::LBA_NIBBLE_MASK}
                   | atb_pkg::LBA_MODE_FLAG;
            res_next.address_overflow = in_data.blk[31:28] != 4'd0;
        end
        else
        begin
            res_next.sector_byte      = in_data.rem1 + 8'd1;
            res_next.cylinder_low     = in_data.num[7:0];
            res_next.cylinder_high    = in_data.num[15:8];
            head                      = in_data.rem;
            res_next.address_overflow = in_data.num[31:16] != 16'd0;
        end
        res_next.drive_head_byte = head | cfg.sel;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/atb_checker.sv -----
// Port-level checker for the task-file address builder, bound to the top level.
`default_nettype none
module atb_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_ready,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] count_byte,
    input  wire logic [7:0] sector_byte,
    input  wire logic [7:0] drive_head_byte,
    input  wire logic       address_overflow
);

    // stalled result transaction stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(count_byte) && $stable(sector_byte)
            && $stable(drive_head_byte) && $stable(address_overflow))
        else $error("result payload changed while stalled");

    // back pressure only comes from a full output register
    a_ready_src: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid && in_ready)
        else $error("pipeline not empty in reset");

endmodule

bind ata_taskfile_address_builder atb_checker u_atb_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .count_byte       (count_byte),
    .sector_byte      (sector_byte),
    .drive_head_byte  (drive_head_byte),
    .address_overflow (address_overflow)
);
`default_nettype wire

// ----- tb/ata_taskfile_address_builder_tb.sv -----
// Testbench for ata_taskfile_address_builder: random and directed task-file checks per geometry.
module ata_taskfile_address_builder_tb;

    localparam int NUM_PHASES     = 16;
    localparam int RANDOM_ITEMS   = 137;
    localparam int HOLD_PHASE     = 6;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 12;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [31:0] blk;
        logic [7:0]  cnt;
        logic [7:0]  cmd;
    } taskfile_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid         = 1'b0;
    logic        in_ready;
    logic [31:0] block_number     = '0;
    logic [7:0]  sector_count     = '0;
    logic [7:0]  command_code     = '0;
    logic        out_valid;
    logic        out_ready        = 1'b0;
    logic [7:0]  count_byte;
    logic [7:0]  sector_byte;
    logic [7:0]  cylinder_low;
    logic [7:0]  cylinder_high;
    logic [7:0]  drive_head_byte;
    logic [7:0]  command_byte_out;
    logic        address_overflow;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [atb_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata           = '0;
    logic [31:0] prdata;
    logic        pready;

    atb_pkg::cfg_t    geom = '{use_lba: atb_pkg::RST_USE_LBA, spt: atb_pkg::RST_SPT,
                               heads: atb_pkg::RST_HEADS, sel: atb_pkg::RST_SELECT};
    taskfile_cmd_t    cmd_pending[$];
    atb_pkg::result_t taskfile_expected[$];
    logic            idle_on       = 1'b1;
    int              gap_left      = 0;
    int              stall_left    = 0;
    int              hold_left     = 0;
    int              hold_req_cnt  = 0;
    int              hold_served   = 0;
    int              taskfile_errors = 0;
    int              cycle_count   = 0;

    ata_taskfile_address_builder i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .block_number     (block_number),
        .sector_count     (sector_count),
        .command_code     (command_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .count_byte       (count_byte),
        .sector_byte      (sector_byte),
        .cylinder_low     (cylinder_low),
        .cylinder_high    (cylinder_high),
        .drive_head_byte  (drive_head_byte),
        .command_byte_out (command_byte_out),
        .address_overflow (address_overflow),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic atb_pkg::result_t build_taskfile(input taskfile_cmd_t c);
        atb_pkg::result_t r;
        logic [31:0] spt_div;
        logic [31:0] hc_div;
        logic [31:0] track;
        logic [31:0] cyl_full;
        logic [7:0]  head;
        r.count_byte = c.cnt;
        r.command_byte_out = c.cmd;
        if (geom.use_lba)
        begin
            r.sector_byte = c.blk[7:0];
            r.cylinder_low = c.blk[15:8];
            r.cylinder_high = c.blk[23:16];
            head = {4'h0, c.blk[27:24] & atb_pkg::LBA_NIBBLE_MASK} | atb_pkg::LBA_MODE_FLAG;
            r.address_overflow = |c.blk[31:28];
        end
        else
        begin
            // zero divisors act as one
            spt_div = (geom.spt == 8'd0) ? 32'd1 : {24'd0, geom.spt};
            hc_div = (geom.heads == 5'd0) ? 32'd1 : {27'd0, geom.heads};
            track = c.blk / spt_div;
            r.sector_byte = 8'(c.blk % spt_div + 32'd1);
            head = 8'(track % hc_div);
            cyl_full = track / hc_div;
            r.cylinder_low = cyl_full[7:0];
            r.cylinder_high = cyl_full[15:8];
            r.address_overflow = cyl_full > 32'h0000_FFFF;
        end
        r.drive_head_byte = head | geom.sel;
        return r;
    endfunction

    // first block that loses address bits under the current setting
    function automatic logic [63:0] overflow_edge();
        logic [63:0] spt_div;
        logic [63:0] hc_div;
        logic [63:0] lim;
        if (geom.use_lba)
            return 64'h1000_0000;
        spt_div = (geom.spt == 8'd0) ? 64'd1 : {56'd0, geom.spt};
        hc_div = (geom.heads == 5'd0) ? 64'd1 : {59'd0, geom.heads};
        lim = spt_div * hc_div * 64'd65536;
        return (lim > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : lim;
    endfunction

    function automatic logic [31:0] pick_block();
        logic [63:0] v;
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom() & 32'h0FFF_FFFF;
            2:
            begin
                v = overflow_edge() + 64'($urandom_range(0, 4000));
                v = (v < 64'd2000) ? 64'd0 : v - 64'd2000;
                return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
            end
            default: return 32'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] field,
                             input logic [31:0] mask);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~mask) | (field & mask);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            atb_pkg::REG_USE_LBA: geom.use_lba = field[0];
            atb_pkg::REG_SPT:     geom.spt = field[7:0];
            atb_pkg::REG_HEADS:   geom.heads = field[4:0];
            atb_pkg::REG_SELECT:  geom.sel = field[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (cmd_pending.size() != 0 || in_valid || taskfile_expected.size() != 0
               || hold_left != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            if (taskfile_errors < REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            taskfile_errors++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        taskfile_cmd_t next_cmd;
        logic          fire;
        if (rst_n)
        begin
            fire = in_valid && in_ready;
            if (fire)
                taskfile_expected.push_back(build_taskfile(
                    '{blk: block_number, cnt: sector_count, cmd: command_code}));
            if (fire || !in_valid)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (cmd_pending.size() != 0)
                begin
                    next_cmd = cmd_pending.pop_front();
                    block_number <= next_cmd.blk;
                    sector_count <= next_cmd.cnt;
                    command_code <= next_cmd.cmd;
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 3) == 0)
                        gap_left <= $urandom_range(1, 3);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        atb_pkg::result_t want;
        logic    rdy;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (taskfile_expected.size() == 0)
                begin
                    if (taskfile_errors < REPORT_LIMIT)
                        $display("unexpected transaction on result channel");
                    taskfile_errors++;
                end
                else
                begin
                    want = taskfile_expected.pop_front();
                    check_field("count_byte", want.count_byte, count_byte);
                    check_field("sector_byte", want.sector_byte, sector_byte);
                    check_field("cylinder_low", want.cylinder_low, cylinder_low);
                    check_field("cylinder_high", want.cylinder_high, cylinder_high);
                    check_field("drive_head_byte", want.drive_head_byte, drive_head_byte);
                    check_field("command_byte_out", want.command_byte_out, command_byte_out);
                    check_field("address_overflow", {7'd0, want.address_overflow},
                                {7'd0, address_overflow});
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                rdy = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left <= $urandom_range(0, 2);
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            out_ready <= rdy && (hold_left == 0);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_served != hold_req_cnt)
        begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic        lba;
        logic [7:0]  spt;
        logic [4:0]  heads;
        logic [7:0]  sel;
        logic [63:0] edge_blk;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                case (p)
                    1: {lba, spt, heads, sel} = {1'b1, 8'd63, 5'd16, 8'hE0};
                    2: {lba, spt, heads, sel} = {1'b0, 8'd0, 5'd0, 8'h00};
                    3: {lba, spt, heads, sel} = {1'b0, 8'd255, 5'd31, 8'hFF};
                    4: {lba, spt, heads, sel} = {1'b0, 8'd1, 5'd1, 8'hA0};
                    5: {lba, spt, heads, sel} = {1'b1, 8'd255, 5'd31, 8'h00};
                    default:
                    begin
                        lba = ($urandom_range(0, 2) == 0);
                        spt = 8'($urandom_range(0, 255));
                        heads = 5'($urandom_range(0, 31));
                        sel = 8'($urandom());
                    end
                endcase
                write_reg(atb_pkg::REG_USE_LBA, {31'd0, lba}, 32'h0000_0001);
                write_reg(atb_pkg::REG_SPT, {24'd0, spt}, 32'h0000_00FF);
                write_reg(atb_pkg::REG_HEADS, {27'd0, heads}, 32'h0000_001F);
                write_reg(atb_pkg::REG_SELECT, {24'd0, sel}, 32'h0000_00FF);
            end
            idle_on <= !(p == 8 || p >= NUM_PHASES - 2);
            if (p < 4)
            begin
                edge_blk = overflow_edge();
                cmd_pending.push_back('{blk: 32'h0000_0000, cnt: 8'h00, cmd: 8'h00});
                cmd_pending.push_back('{blk: 32'hFFFF_FFFF, cnt: 8'hFF, cmd: 8'hFF});
                cmd_pending.push_back('{blk: 32'h0FFF_FFFF, cnt: 8'h01, cmd: 8'h20});
                cmd_pending.push_back('{blk: 32'h1000_0000, cnt: 8'h80, cmd: 8'h30});
                cmd_pending.push_back('{blk: edge_blk[31:0] - 32'd1, cnt: 8'h7F, cmd: 8'hC8});
                cmd_pending.push_back('{blk: edge_blk[31:0], cnt: 8'h10, cmd: 8'hCA});
            end
            else
            begin
                if (p == HOLD_PHASE)
                    hold_req_cnt <= hold_req_cnt + 1;
                for (int i = 0; i < RANDOM_ITEMS; i++)
                    cmd_pending.push_back('{blk: pick_block(), cnt: 8'($urandom()),
                                            cmd: 8'($urandom())});
            end
            wait_drained();
        end
        if (taskfile_errors == 0 && taskfile_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- ata_taskfile_address_builder.f -----
rtl/atb_pkg.sv
rtl/atb_cfg.sv
rtl/atb_div_stage.sv
rtl/atb_format.sv
rtl/ata_taskfile_address_builder.sv
rtl/atb_checker.sv
tb/ata_taskfile_address_builder_tb.sv
